### hdl/sparse_triplet_add_merge_unit_defines.svh
// ----------------------------------------------------------------------------
// sparse_triplet_add_merge_unit_defines.svh
// Assertion macros used by the checker of the sparse add/merge unit.
// ----------------------------------------------------------------------------
`ifndef SPARSE_TRIPLET_ADD_MERGE_UNIT_DEFINES_SVH
`define SPARSE_TRIPLET_ADD_MERGE_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define STAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define STAM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/stam_pkg.sv
// ----------------------------------------------------------------------------
// stam_pkg
// Types, codes and fixed widths of the sparse triplet add/merge unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stam_pkg;

  localparam int MAX_TERMS_DEF  = 32;
  localparam int INDEX_BITS_DEF = 8;
  localparam int VALUE_BITS_DEF = 16;

  // fixed field widths on the ports
  localparam int IN_IDX_W  = 8;
  localparam int IN_VAL_W  = 16;
  localparam int OUT_VAL_W = 17;
  localparam int DIM_W     = 9;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int S_TDATA_W = 2 * IN_IDX_W + IN_VAL_W;
  localparam int M_TDATA_W = 40;
  localparam int M_PAD_W   = M_TDATA_W - 2 * IN_IDX_W - OUT_VAL_W;
  localparam int M_TUSER_W = 3;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_MERGE  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_ENTRY    = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_MISMATCH = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_A_ROWS = 2'd0,
    REG_A_COLS = 2'd1,
    REG_B_ROWS = 2'd2,
    REG_B_COLS = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_STEP,
    SEQ_EMIT
  } seq_state_e;

  typedef enum logic [1:0] {
    ALU_BOTH,
    ALU_A_ONLY,
    ALU_B_ONLY
  } alu_mode_e;

  typedef struct packed {
    logic take_a;
    logic take_b;
  } alu_step_t;

endpackage

### hdl/stam_merge_alu.sv
// ----------------------------------------------------------------------------
// stam_merge_alu
// Shared merge unit: compares the two list heads in row-major order, picks
// which heads advance and adds the chosen values with one adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stam_merge_alu import stam_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  alu_mode_e                      mode_i,
  input  logic [INDEX_BITS-1:0]          a_row_i,
  input  logic [INDEX_BITS-1:0]          a_col_i,
  input  logic signed [VALUE_BITS-1:0]   a_val_i,
  input  logic [INDEX_BITS-1:0]          b_row_i,
  input  logic [INDEX_BITS-1:0]          b_col_i,
  input  logic signed [VALUE_BITS-1:0]   b_val_i,
  output alu_step_t                      step_o,
  output logic [IN_IDX_W-1:0]            row_o,
  output logic [IN_IDX_W-1:0]            col_o,
  output logic signed [OUT_VAL_W-1:0]    value_o
);

  localparam int SUM_W = VALUE_BITS + 1;

  logic                    same_pos;
  logic                    a_first;
  logic signed [SUM_W-1:0] add_a;
  logic signed [SUM_W-1:0] add_b;
  logic signed [SUM_W-1:0] sum;

  assign same_pos = (a_row_i == b_row_i) && (a_col_i == b_col_i);
  assign a_first  = (a_row_i < b_row_i) || ((a_row_i == b_row_i) && (a_col_i < b_col_i));

  always_comb begin
    step_o = '0;
    unique case (mode_i)
      ALU_BOTH: begin
        if (same_pos) begin
          step_o.take_a = 1'b1;
          step_o.take_b = 1'b1;
        end else if (a_first) begin
          step_o.take_a = 1'b1;
        end else begin
          step_o.take_b = 1'b1;
        end
      end
      ALU_A_ONLY: step_o.take_a = 1'b1;
      ALU_B_ONLY: step_o.take_b = 1'b1;
      default:    step_o = '0;
    endcase
  end

  assign add_a   = step_o.take_a ? SUM_W'(a_val_i) : '0;
  assign add_b   = step_o.take_b ? SUM_W'(b_val_i) : '0;
  assign sum     = add_a + add_b;
  assign value_o = OUT_VAL_W'(sum);

  assign row_o = step_o.take_a ? IN_IDX_W'(a_row_i) : IN_IDX_W'(b_row_i);
  assign col_o = step_o.take_a ? IN_IDX_W'(a_col_i) : IN_IDX_W'(b_col_i);

endmodule

### hdl/sparse_triplet_add_merge_unit.sv
// ----------------------------------------------------------------------------
// sparse_triplet_add_merge_unit
// Adds two sparse matrices given as row-major (row, col, value) triplet lists.
// A load word (tuser 0 or 1) appends one triplet to store A or B, and the
// unit stays ready for the next word. A merge word (tuser 2) makes the
// unit busy: it first checks that the configured A and B dimensions agree,
// then walks both stores with one shared compare/add unit. Each output word
// is computed into the output register (SEQ_STEP) and then handed over
// (SEQ_EMIT), where the unit waits while the output side stalls; no new
// input word is taken until the merge ends. Equal positions are summed
// (a zero sum is still sent), a mismatch or an empty sum gives a single
// status word. tlast marks the last word of a merge, tuser[2] flags that
// a load was dropped because a store was full. A merge empties both
// stores. Dimension registers sit at byte addresses 0, 4, 8, 12.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_triplet_add_merge_unit import stam_pkg::*; #(
  parameter int MAX_TERMS  = MAX_TERMS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // stream in
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // row_index, col_index, entry_value
  input  logic [1:0]           s_axis_tuser,  // operation
  // stream out
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // out_row, out_col, out_value, zero pad
  output logic [M_TUSER_W-1:0] m_axis_tuser,  // status, dropped
  output logic                 m_axis_tlast,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int ENT_W = 2 * INDEX_BITS + VALUE_BITS;
  localparam int RAW_W = (VALUE_BITS > IN_VAL_W) ? VALUE_BITS : IN_VAL_W;

  typedef struct packed {
    logic s_ready;
    logic step;
    logic finish;
  } seq_ctrl_t;

  // configuration registers
  logic [DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic             cfg_wr;
  reg_idx_e         cfg_idx;

  // stores and counters
  logic [ENT_W-1:0] a_mem_q [MAX_TERMS];
  logic [ENT_W-1:0] b_mem_q [MAX_TERMS];
  logic [CNT_W-1:0] a_cnt_q, b_cnt_q;
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d;
  logic             ovf_q;

  // sequencer
  seq_state_e state_q, state_d;
  seq_ctrl_t  ctrl;

  // output register
  logic [M_TDATA_W-1:0] out_data_q, out_data_d;
  logic [M_TUSER_W-1:0] out_user_q, out_user_d;
  logic                 out_last_q, out_last_d;

  // input decode
  op_e                     in_op;
  logic                    in_acc;
  logic [INDEX_BITS-1:0]   ld_row, ld_col;
  logic [RAW_W-1:0]        ld_raw;
  logic [ENT_W-1:0]        ld_entry;
  logic                    a_full, b_full;

  // merge step
  logic                    dims_bad;
  logic                    a_left, b_left;
  alu_mode_e               alu_mode;
  alu_step_t               alu_step;
  logic [IN_IDX_W-1:0]     alu_row, alu_col;
  logic signed [OUT_VAL_W-1:0] alu_value;
  logic [ENT_W-1:0]        a_head, b_head;
  status_e                 step_status;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= '0;
      a_cols_q <= '0;
      b_rows_q <= '0;
      b_cols_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_A_ROWS: a_rows_q <= pwdata[DIM_W-1:0];
        REG_A_COLS: a_cols_q <= pwdata[DIM_W-1:0];
        REG_B_ROWS: b_rows_q <= pwdata[DIM_W-1:0];
        REG_B_COLS: b_cols_q <= pwdata[DIM_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_A_ROWS: prdata = APB_DW'(a_rows_q);
      REG_A_COLS: prdata = APB_DW'(a_cols_q);
      REG_B_ROWS: prdata = APB_DW'(b_rows_q);
      REG_B_COLS: prdata = APB_DW'(b_cols_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------- loads ----------------
  assign in_op    = op_e'(s_axis_tuser);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign ld_row   = INDEX_BITS'(s_axis_tdata[IN_IDX_W-1:0]);
  assign ld_col   = INDEX_BITS'(s_axis_tdata[2*IN_IDX_W-1:IN_IDX_W]);
  assign ld_raw   = RAW_W'(s_axis_tdata[S_TDATA_W-1:2*IN_IDX_W]);
  assign ld_entry = {ld_raw[VALUE_BITS-1:0], ld_col, ld_row};
  assign a_full   = (a_cnt_q == CNT_W'(MAX_TERMS));
  assign b_full   = (b_cnt_q == CNT_W'(MAX_TERMS));

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_op == OP_LOAD_A) && !a_full) begin
      a_mem_q[a_cnt_q[IDX_W-1:0]] <= ld_entry;
    end
    if (in_acc && (in_op == OP_LOAD_B) && !b_full) begin
      b_mem_q[b_cnt_q[IDX_W-1:0]] <= ld_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_cnt_q <= '0;
      b_cnt_q <= '0;
      ovf_q   <= 1'b0;
    end else if (ctrl.finish) begin
      a_cnt_q <= '0;
      b_cnt_q <= '0;
      ovf_q   <= 1'b0;
    end else if (in_acc) begin
      unique case (in_op)
        OP_LOAD_A: begin
          if (a_full) ovf_q <= 1'b1;
          else        a_cnt_q <= a_cnt_q + CNT_W'(1);
        end
        OP_LOAD_B: begin
          if (b_full) ovf_q <= 1'b1;
          else        b_cnt_q <= b_cnt_q + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: if (s_axis_tvalid && (in_op == OP_MERGE)) state_d = SEQ_STEP;
      SEQ_STEP: state_d = SEQ_EMIT;
      SEQ_EMIT: begin
        if (m_axis_tready) state_d = out_last_q ? SEQ_IDLE : SEQ_STEP;
      end
      default:  state_d = SEQ_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_q)
      SEQ_IDLE: ctrl.s_ready = 1'b1;
      SEQ_STEP: ctrl.step    = 1'b1;
      SEQ_EMIT: ctrl.finish  = m_axis_tready && out_last_q;
      default:  ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SEQ_IDLE;
    else         state_q <= state_d;
  end

  // ---------------- merge step ----------------
  assign dims_bad = (a_rows_q != b_rows_q) || (a_cols_q != b_cols_q);
  assign a_left   = (i_q < a_cnt_q);
  assign b_left   = (j_q < b_cnt_q);
  assign a_head   = a_mem_q[i_q[IDX_W-1:0]];
  assign b_head   = b_mem_q[j_q[IDX_W-1:0]];

  always_comb begin
    priority if (a_left && b_left) alu_mode = ALU_BOTH;
    else if (b_left)               alu_mode = ALU_B_ONLY;
    else                           alu_mode = ALU_A_ONLY;
  end

  stam_merge_alu #(
    .INDEX_BITS (INDEX_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_alu (
    .mode_i  (alu_mode),
    .a_row_i (a_head[INDEX_BITS-1:0]),
    .a_col_i (a_head[2*INDEX_BITS-1:INDEX_BITS]),
    .a_val_i (a_head[ENT_W-1:2*INDEX_BITS]),
    .b_row_i (b_head[INDEX_BITS-1:0]),
    .b_col_i (b_head[2*INDEX_BITS-1:INDEX_BITS]),
    .b_val_i (b_head[ENT_W-1:2*INDEX_BITS]),
    .step_o  (alu_step),
    .row_o   (alu_row),
    .col_o   (alu_col),
    .value_o (alu_value)
  );

  always_comb begin
    i_d         = i_q;
    j_d         = j_q;
    step_status = STAT_ENTRY;
    out_last_d  = 1'b1;
    out_data_d  = '0;
    priority if (dims_bad) begin
      step_status = STAT_MISMATCH;
    end else if (a_left || b_left) begin
      i_d        = i_q + CNT_W'(alu_step.take_a);
      j_d        = j_q + CNT_W'(alu_step.take_b);
      out_last_d = !(i_d < a_cnt_q) && !(j_d < b_cnt_q);
      out_data_d = {{M_PAD_W{1'b0}}, alu_value, alu_col, alu_row};
    end else begin
      step_status = STAT_EMPTY;
    end
    out_user_d = {ovf_q, step_status};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
    end else if (in_acc && (in_op == OP_MERGE)) begin
      i_q <= '0;
      j_q <= '0;
    end else if (ctrl.step) begin
      i_q <= i_d;
      j_q <= j_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_last_q <= 1'b0;
    end else if (ctrl.step) begin
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.step) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign s_axis_tready = ctrl.s_ready;
  assign m_axis_tvalid = (state_q == SEQ_EMIT);
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### hdl/stam_checker.sv
// ----------------------------------------------------------------------------
// stam_checker
// Port-level checks of the sparse triplet add/merge unit, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sparse_triplet_add_merge_unit_defines.svh"

module stam_checker import stam_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  input logic [1:0]           s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [M_TUSER_W-1:0] m_axis_tuser,
  input logic                 m_axis_tlast,
  input logic                 psel,
  input logic                 penable,
  input logic                 pwrite,
  input logic [APB_AW-1:0]    paddr,
  input logic [APB_DW-1:0]    pwdata,
  input logic [APB_DW-1:0]    prdata,
  input logic                 pready
);

  // while reset is held the sequencer returns to idle: input ready, no output
  `STAM_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> (!m_axis_tvalid && s_axis_tready), "reset state wrong")

  `STAM_ASSERT(a_busy_excl, s_axis_tready |-> !m_axis_tvalid, "input ready while a result is out")

  `STAM_ASSERT(a_status_last, (m_axis_tvalid && (m_axis_tuser[1:0] != STAT_ENTRY)) |-> m_axis_tlast, "status word not last")

  `STAM_ASSERT(a_merge_busy, (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_MERGE)) |=> !s_axis_tready, "ready right after merge")

  `STAM_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled word changed")

endmodule

bind sparse_triplet_add_merge_unit stam_checker u_stam_checker (.*);
